[rtl/cfct_pkg.sv]
// Shared types, widths and register codes for the chunk frustum cull test.
`timescale 1ns / 1ps
package cfct_pkg;

  localparam int SIZE_W  = 11;
  localparam int AMP_W   = 24;
  localparam int NRM_W   = 16;
  localparam int DIST_W  = 32;
  localparam int COORD_W = 16;
  localparam int SLOT_W  = 3;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int ABOX_W = COORD_W + 1 + SIZE_W + 1;
  localparam int PRD_W  = NRM_W + ABOX_W;
  localparam int ABS_W  = NRM_W + 1;
  localparam int RAD_W  = SIZE_W + ABS_W;
  localparam int PY_W   = AMP_W + NRM_W - 1;
  localparam int T_W    = PRD_W + 3;
  localparam int U_W    = DIST_W + 17;
  localparam int S_W    = T_W + 9;

  localparam logic [SIZE_W-1:0] SIZE_RST = SIZE_W'(32);
  localparam logic [AMP_W-1:0]  AMP_RST  = AMP_W'(256);

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE  = CFG_IDX_W'(1);

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_TEST = 1'b1;

  typedef struct packed {
    logic signed [NRM_W-1:0]  nx;
    logic signed [NRM_W-1:0]  ny;
    logic signed [NRM_W-1:0]  nz;
    logic signed [DIST_W-1:0] offs;
  } plane_t;

  typedef struct packed {
    logic adv2;
    logic adv3;
  } lane_ctl_t;

endpackage

[rtl/cfct_plane_lane.sv]
// One plane lane: products, partial sums and the outside decision for a chunk box.
`timescale 1ns / 1ps
module cfct_plane_lane (
  input  logic                                  clk,
  input  cfct_pkg::lane_ctl_t                   ctl,
  input  cfct_pkg::plane_t                      plane,
  input  logic signed [cfct_pkg::ABOX_W-1:0]    box_a,
  input  logic signed [cfct_pkg::ABOX_W-1:0]    box_b,
  input  logic        [cfct_pkg::SIZE_W-1:0]    size,
  input  logic        [cfct_pkg::AMP_W-1:0]     amp,
  output logic                                  outside
);
  import cfct_pkg::*;

  logic signed [ABS_W-1:0]  nx_ext;
  logic signed [ABS_W-1:0]  nz_ext;
  logic        [ABS_W-1:0]  nx_abs;
  logic        [ABS_W-1:0]  nz_abs;
  logic        [NRM_W-2:0]  ny_pos;

  logic signed [PRD_W-1:0]  px_r, px_nxt;
  logic signed [PRD_W-1:0]  pz_r, pz_nxt;
  logic        [RAD_W-1:0]  rx_r, rx_nxt;
  logic        [RAD_W-1:0]  rz_r, rz_nxt;
  logic        [PY_W-1:0]   py_r, py_nxt;
  logic signed [DIST_W-1:0] dist_r;

  logic signed [T_W-1:0]    t_r, t_nxt;
  logic signed [U_W-1:0]    u_r, u_nxt;
  logic signed [S_W-1:0]    s_sum;

  always_comb begin
    nx_ext = ABS_W'(plane.nx);
    nz_ext = ABS_W'(plane.nz);
    nx_abs = nx_ext[ABS_W-1] ? ABS_W'(-nx_ext) : nx_ext;
    nz_abs = nz_ext[ABS_W-1] ? ABS_W'(-nz_ext) : nz_ext;
    ny_pos = plane.ny[NRM_W-1] ? '0 : plane.ny[NRM_W-2:0];
    px_nxt = plane.nx * box_a;
    pz_nxt = plane.nz * box_b;
    rx_nxt = size * nx_abs;
    rz_nxt = size * nz_abs;
    py_nxt = amp * ny_pos;
  end

  always_ff @(posedge clk) begin
    if (ctl.adv2) begin
      px_r   <= px_nxt;
      pz_r   <= pz_nxt;
      rx_r   <= rx_nxt;
      rz_r   <= rz_nxt;
      py_r   <= py_nxt;
      dist_r <= plane.offs;
    end
  end

  always_comb begin
    t_nxt = T_W'(px_r) + T_W'(pz_r) + T_W'(rx_r) + T_W'(rz_r);
    u_nxt = U_W'($signed({dist_r, 15'd0})) + U_W'({py_r, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (ctl.adv3) begin
      t_r <= t_nxt;
      u_r <= u_nxt;
    end
  end

  assign s_sum   = S_W'($signed({t_r, 8'd0})) + S_W'(u_r);
  assign outside = s_sum[S_W-1];

endmodule

[rtl/chunk_frustum_cull_test.sv]
// Top level of the chunk frustum cull test pipeline.
//
// Usage: requests enter on the in_ stream. in_tuser is the kind: 0 loads one
// plane (normal, offset) into the slot given, 1 tests one chunk (chunk_x,
// chunk_z) against all NUM_PLANES planes. A load yields no result; a test
// yields one result on the out_ stream, out_tdata[0] = 1 when the chunk box
// touches or lies inside every plane.
// The cfg_ channel writes chunk_size (index 0) and amplitude_height (index 1)
// and is always ready; the user writes it only while the pipeline is empty,
// which the block does not enforce. Throughput: one request per cycle while
// the receiver takes results; the pipeline is the box multiply, the per-plane
// multiplier lanes, the per-plane adder stage and the output register. Loads
// take effect in order with tests, at the lane input stage.
// Reset clears the plane store to zero planes (never cull), sets chunk_size
// to 32 and amplitude_height to 256, and empties the pipeline.
// When the receiver stalls, the result holds in the output register while
// bubbles ahead of it fill; in_tready drops only when every stage is full.
`timescale 1ns / 1ps
module chunk_frustum_cull_test #(
  parameter int NUM_PLANES = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // [2:0] plane_slot, [18:3] normal_x, [34:19] normal_y, [50:35] normal_z,
  // [82:51] plane_offset, [98:83] chunk_x, [114:99] chunk_z, rest zero
  input  logic [cfct_pkg::IN_DATA_W-1:0]      in_tdata,
  // [0] kind
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // [0] visible, rest zero
  output logic [cfct_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [cfct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cfct_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import cfct_pkg::*;

  logic [SIZE_W-1:0] size_r;
  logic [AMP_W-1:0]  amp_r;

  plane_t plane_r [NUM_PLANES];

  logic                      v1_r, v2_r, v3_r, out_v_r;
  logic                      kind1_r;
  logic [SLOT_W-1:0]         slot1_r;
  plane_t                    pl1_r;
  logic signed [ABOX_W-1:0]  a1_r, b1_r, a_nxt, b_nxt;
  logic                      inf_r;

  logic out_en, en3, en2, en1;
  logic load_wr;
  lane_ctl_t lane_ctl;
  logic [NUM_PLANES-1:0] outside;

  logic signed [COORD_W:0]   x_odd, z_odd;
  logic signed [SIZE_W:0]    size_s;
  plane_t                    in_plane;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_RST;
      amp_r  <= AMP_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CHUNK_SIZE: size_r <= cfg_data[SIZE_W-1:0];
        REG_AMPLITUDE:  amp_r  <= cfg_data[AMP_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_en    = !out_v_r || out_tready;
  assign en3       = !v3_r || out_en;
  assign en2       = !v2_r || en3;
  assign en1       = !v1_r || en2;
  assign in_tready = en1;

  assign lane_ctl.adv2 = en2;
  assign lane_ctl.adv3 = en3;
  assign load_wr       = v1_r && en2 && (kind1_r == KIND_LOAD);

  always_comb begin
    x_odd         = $signed({in_tdata[98:83], 1'b1});
    z_odd         = $signed({in_tdata[114:99], 1'b1});
    size_s        = $signed({1'b0, size_r});
    a_nxt         = x_odd * size_s;
    b_nxt         = z_odd * size_s;
    in_plane.nx   = in_tdata[18:3];
    in_plane.ny   = in_tdata[34:19];
    in_plane.nz   = in_tdata[50:35];
    in_plane.offs = in_tdata[82:51];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (en1)    v1_r    <= in_tvalid;
      if (en2)    v2_r    <= v1_r && (kind1_r == KIND_TEST);
      if (en3)    v3_r    <= v2_r;
      if (out_en) out_v_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_tvalid) begin
      kind1_r <= in_tuser;
      slot1_r <= in_tdata[SLOT_W-1:0];
      pl1_r   <= in_plane;
      a1_r    <= a_nxt;
      b1_r    <= b_nxt;
    end
    if (out_en && v3_r) begin
      inf_r <= ~|outside;
    end
  end

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_lane
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        plane_r[i] <= '0;
      end else if (load_wr && slot1_r == SLOT_W'(i)) begin
        plane_r[i] <= pl1_r;
      end
    end

    cfct_plane_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .plane   (plane_r[i]),
      .box_a   (a1_r),
      .box_b   (b1_r),
      .size    (size_r),
      .amp     (amp_r),
      .outside (outside[i])
    );
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{(OUT_DATA_W-1){1'b0}}, inf_r};

  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a stalled result");

  a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(v3_r))
    else $error("result appeared without a test in the last stage");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !out_en) |=> v3_r)
    else $error("stalled test dropped from the adder stage");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && en2 && kind1_r == KIND_LOAD) |=> !v2_r)
    else $error("plane load entered the lane stage");

endmodule

[tb/tb_chunk_frustum_cull_test.sv]
// Self-checking testbench: plane loads and chunk visibility tests against a six-plane predictor.
`timescale 1ns / 1ps
module tb_chunk_frustum_cull_test;
  import cfct_pkg::*;

  localparam int NUM_PLANES = 6;
  localparam int PIPE_LAT   = 3;
  localparam int IDLE_PCT   = 37;
  localparam int PHASES     = 6;
  localparam int PHASE_REQS = 90;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

  typedef struct {
    logic                      kind;
    logic [SLOT_W-1:0]         slot;
    logic signed [NRM_W-1:0]   nx;
    logic signed [NRM_W-1:0]   ny;
    logic signed [NRM_W-1:0]   nz;
    logic signed [DIST_W-1:0]  off;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] z;
  } req_t;

  typedef struct {
    req_t r;
    int   want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  plane_t            plane_mem [NUM_PLANES];
  logic [SIZE_W-1:0] cur_size;
  logic [AMP_W-1:0]  cur_amp;
  logic              visible_q [$];
  row_t              dir_tab [$];
  int                mismatch_cnt = 0;
  bit                steady = 1'b0;
  int                focus_cx, focus_cz;
  longint            focus_x, focus_y, focus_z;

  chunk_frustum_cull_test #(.NUM_PLANES(NUM_PLANES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic predict_visible(input logic signed [COORD_W-1:0] x,
                                           input logic signed [COORD_W-1:0] z);
    longint sz, amp, cx, cz, hxz, nx, ny, nz, ofs_v, rad, d;
    logic   vis;
    sz  = longint'(cur_size);
    amp = longint'(cur_amp);
    cx  = (2 * longint'(x) * sz + sz) * 256;
    cz  = (2 * longint'(z) * sz + sz) * 256;
    hxz = sz * 256;
    vis = 1'b1;
    for (int i = 0; i < NUM_PLANES; i++) begin
      nx    = longint'($signed(plane_mem[i].nx));
      ny    = longint'($signed(plane_mem[i].ny));
      nz    = longint'($signed(plane_mem[i].nz));
      ofs_v = longint'($signed(plane_mem[i].offs));
      rad   = hxz * magnitude(nx) + amp * magnitude(ny) + hxz * magnitude(nz);
      d     = nx * cx + ny * amp + nz * cz + ofs_v * 32768;
      if (d < -rad) vis = 1'b0;
    end
    return vis;
  endfunction

  function automatic row_t mk(input logic kind, input logic [SLOT_W-1:0] slot,
                              input logic signed [NRM_W-1:0] nx,
                              input logic signed [NRM_W-1:0] ny,
                              input logic signed [NRM_W-1:0] nz,
                              input logic signed [DIST_W-1:0] off,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] z, input int want);
    row_t w;
    w.r    = '{kind: kind, slot: slot, nx: nx, ny: ny, nz: nz, off: off, x: x, z: z};
    w.want = want;
    return w;
  endfunction

  task automatic add_row(input row_t w);
    dir_tab.insert(dir_tab.size(), w);
  endtask

  function automatic req_t rand_req();
    req_t   r;
    longint n_dot, dist_v, margin;
    int     mode, sz;
    sz     = int'(cur_size);
    r.kind = ($urandom_range(0, 99) < 25) ? KIND_LOAD : KIND_TEST;
    r.slot = ($urandom_range(0, 99) < 90) ? SLOT_W'($urandom_range(0, NUM_PLANES - 1))
                                          : SLOT_W'($urandom_range(NUM_PLANES, 7));
    r.nx   = NRM_W'($urandom);
    r.ny   = NRM_W'($urandom);
    r.nz   = NRM_W'($urandom);
    r.off  = DIST_W'($urandom);
    r.x    = COORD_W'($urandom);
    r.z    = COORD_W'($urandom);
    if (r.kind == KIND_LOAD) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        if (mode < 3) begin
          r.nx = NRM_W'(int'($urandom_range(0, 32768)) - 16384);
          r.ny = NRM_W'(int'($urandom_range(0, 32768)) - 16384);
          r.nz = NRM_W'(int'($urandom_range(0, 32768)) - 16384);
        end
        // place the plane near the focus point, with the focus mostly inside
        n_dot  = longint'(r.nx) * focus_x + longint'(r.ny) * focus_y + longint'(r.nz) * focus_z;
        margin = (longint'($urandom_range(0, 10 * sz + 16)) - 2 * longint'(sz)) * 256;
        dist_v = -(n_dot / 64) + margin;
        if (dist_v > 64'sd2147483647) dist_v = 64'sd2147483647;
        if (dist_v < -64'sd2147483648) dist_v = -64'sd2147483648;
        r.off = DIST_W'(dist_v);
      end else if (mode < 8) begin
        r.nx  = '0;
        r.ny  = '0;
        r.nz  = '0;
        r.off = ($urandom_range(0, 9) == 0) ? -DIST_W'($urandom_range(1, 1000))
                                            : DIST_W'($urandom_range(0, 1000));
      end
    end else if ($urandom_range(0, 99) < 70) begin
      r.x = COORD_W'(focus_cx + int'($urandom_range(0, 8)) - 4);
      r.z = COORD_W'(focus_cz + int'($urandom_range(0, 8)) - 4);
    end
    return r;
  endfunction

  task automatic note_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("mismatch: %s", msg);
    mismatch_cnt++;
  endtask

  task automatic send_req(input req_t r, input int want);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.kind;
    in_tdata  <= {5'b0, r.z, r.x, r.off, r.nz, r.ny, r.nx, r.slot};
    do @(posedge clk); while (!in_tready);
    if (r.kind == KIND_LOAD) begin
      if (r.slot < NUM_PLANES)
        plane_mem[r.slot] = '{nx: r.nx, ny: r.ny, nz: r.nz, offs: r.off};
    end else if (want >= 0) begin
      visible_q.insert(visible_q.size(), want[0]);
    end else begin
      visible_q.insert(visible_q.size(), predict_visible(r.x, r.z));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    in_tvalid <= 1'b0;
    while (visible_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CHUNK_SIZE: cur_size = data[SIZE_W-1:0];
      REG_AMPLITUDE:  cur_amp  = data[AMP_W-1:0];
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : out_side
    logic want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (visible_q.size() == 0) begin
          note_mismatch($sformatf("unexpected result %0h", out_tdata));
        end else begin
          want = visible_q.pop_front();
          if (out_tdata !== {{(OUT_DATA_W-1){1'b0}}, want})
            note_mismatch($sformatf("visible expected %0h got %0h", want, out_tdata));
        end
      end
      out_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  initial begin : stim
    logic [CFG_DATA_W-1:0] phase_size [PHASES];
    logic [CFG_DATA_W-1:0] phase_amp [PHASES];
    for (int i = 0; i < NUM_PLANES; i++) plane_mem[i] = '0;
    cur_size = SIZE_RST;
    cur_amp  = AMP_RST;

    // after reset, every plane is zero and never culls
    add_row(mk(KIND_TEST, 0, '1, '1, '1, '1, 0, 0, 1));
    add_row(mk(KIND_TEST, 7, 0, 0, 0, 0, -32768, 32767, 1));
    add_row(mk(KIND_TEST, 0, -1, -1, -1, -1, 32767, -32768, 1));
    // slots beyond the store are dropped
    add_row(mk(KIND_LOAD, 6, 0, 0, 0, -1, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, 1));
    add_row(mk(KIND_LOAD, 7, 0, 0, 0, 32'sh8000_0000, -1, -1, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 5, -5, 1));
    // zero normal: the sign of the offset alone decides
    add_row(mk(KIND_LOAD, 0, 0, 0, 0, -1, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(KIND_LOAD, 0, 0, 0, 0, 0, 16'sh7fff, 16'sh7fff, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 3, 3, 1));
    add_row(mk(KIND_LOAD, 5, 0, 0, 0, 32'sh8000_0000, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, 0));
    add_row(mk(KIND_LOAD, 5, 0, 0, 0, 32'sh7fff_ffff, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, 1));
    // box touching a plane along x
    add_row(mk(KIND_LOAD, 1, -16384, 0, 0, 0, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 1, 0, -1));
    add_row(mk(KIND_LOAD, 1, -16384, 0, 0, -1, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, -1, 0, -1));
    // extreme normals and offsets
    add_row(mk(KIND_LOAD, 2, -32768, 32767, -32768, 32'sh7fff_ffff,
               -32768, -32768, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, -32768, -32768, -1));
    add_row(mk(KIND_LOAD, 3, 32767, -32768, 32767, 32'sh8000_0000, 0, 0, -1));
    add_row(mk(KIND_TEST, 0, 0, 0, 0, 0, 32767, 32767, -1));

    phase_size = '{24'd32, 24'd0, 24'hFF_FFFF, 24'd1, 24'd1024, 24'd0};
    phase_amp  = '{24'd256, 24'd0, 24'hFF_FFFF, 24'd1, 24'hFF_FFFF, 24'd0};
    phase_size[PHASES-1] = CFG_DATA_W'($urandom_range(1, 64));
    phase_amp[PHASES-1]  = CFG_DATA_W'($urandom);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_req(dir_tab[i].r, dir_tab[i].want);

    for (int p = 0; p < PHASES; p++) begin
      write_reg(REG_CHUNK_SIZE, phase_size[p]);
      write_reg(REG_AMPLITUDE, phase_amp[p]);
      if (p == 2) begin
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom));
      end
      focus_cx = int'($urandom_range(0, 200)) - 100;
      focus_cz = int'($urandom_range(0, 200)) - 100;
      focus_x  = longint'(focus_cx) * longint'(cur_size) + longint'(cur_size / 2);
      focus_z  = longint'(focus_cz) * longint'(cur_size) + longint'(cur_size / 2);
      focus_y  = longint'($urandom_range(0, int'(cur_amp >> 8)));
      steady   = (p == 4);
      repeat (PHASE_REQS) send_req(rand_req(), -1);
      steady = 1'b0;
    end

    in_tvalid <= 1'b0;
    while (visible_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
    if (mismatch_cnt == 0 && visible_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/cfct_pkg.sv
rtl/cfct_plane_lane.sv
rtl/chunk_frustum_cull_test.sv
tb/tb_chunk_frustum_cull_test.sv
